/* hdl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// Distinct subsequence counter package
// Action codes and the control bundle that is broadcast along the cell row.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Width of the emitted count field.
  localparam int OUT_COUNT_W = 32;

  // Width of a pattern or source byte.
  localparam int SYM_W = 8;

  // Codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_SOURCE = 2'd1,
    ACT_FINISH = 2'd2
  } dsc_action_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             clear;
    logic [SYM_W-1:0] symbol;
  } dsc_ctl_t;

endpackage

/* hdl/distinct_subsequence_counter_top.sv */
// Latency: a finish transfer yields its result in the output register on the next cycle.
// Throughput: one item per cycle while in_ready is high; every cell of the row updates in the same cycle.
// Append and source items produce no result; a stalled result holds back the input.
// Reset (rst_n low, synchronous) clears cell occupancy, both flags and the output valid.
// Pattern bytes and counts need no clearing pass; a cell clears its count when loaded.
// ----------------------------------------------------------------------------
// Distinct subsequence counter top level
// Counts occurrences of a loaded pattern as a subsequence of a streamed source.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_top #(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_count,
  output logic        out_count_saturated,
  output logic        out_pattern_overflow
);
  import dsc_pkg::*;

  dsc_ctl_t                 ctl;
  logic                     in_fire;
  logic                     is_append;
  logic                     is_source;
  logic                     is_finish;
  logic [MAX_PATTERN-1:0]   act_vec;
  logic [MAX_PATTERN-1:0]   sat_vec;
  logic [MAX_PATTERN-1:0]   last_vec;
  logic [COUNT_WIDTH-1:0]   cnt_arr [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0]   tail_cnt;
  logic [COUNT_WIDTH-1:0]   emit_cnt;
  logic [OUT_COUNT_W-1:0]   emit_low;
  logic                     sat_r;
  logic                     sat_nxt;
  logic                     ovf_r;
  logic                     ovf_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [OUT_COUNT_W-1:0]   out_count_r;
  logic                     out_sat_r;
  logic                     out_ovf_r;

  // Input transfer and action decode.
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    is_append = 1'b0;
    is_source = 1'b0;
    is_finish = 1'b0;
    case (dsc_action_t'(in_action))
      ACT_APPEND: is_append = in_fire;
      ACT_SOURCE: is_source = in_fire;
      ACT_FINISH: is_finish = in_fire;
      default: begin
        is_append = 1'b0;
      end
    endcase
  end

  assign ctl.load   = is_append;
  assign ctl.step   = is_source;
  assign ctl.clear  = is_finish;
  assign ctl.symbol = in_symbol;

  // Row of cells; the empty prefix ahead of cell 0 counts one.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      dsc_cell #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .prev_active (1'b1),
        .prev_cnt    (COUNT_WIDTH'(1)),
        .active      (act_vec[k]),
        .cnt         (cnt_arr[k]),
        .sat_evt     (sat_vec[k])
      );
    end else begin : g_body
      dsc_cell #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .prev_active (act_vec[k-1]),
        .prev_cnt    (cnt_arr[k-1]),
        .active      (act_vec[k]),
        .cnt         (cnt_arr[k]),
        .sat_evt     (sat_vec[k])
      );
    end

    // The last occupied cell holds the count for the whole pattern.
    if (k == MAX_PATTERN - 1) begin : g_last_end
      assign last_vec[k] = act_vec[k];
    end else begin : g_last_mid
      assign last_vec[k] = act_vec[k] & ~act_vec[k+1];
    end
  end

  // Select the tail count with an AND-OR over the one-hot last marker.
  always_comb begin
    tail_cnt = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tail_cnt = tail_cnt | (cnt_arr[k] & {COUNT_WIDTH{last_vec[k]}});
    end
  end

  assign emit_cnt = act_vec[0] ? tail_cnt : COUNT_WIDTH'(1);

  if (COUNT_WIDTH >= OUT_COUNT_W) begin : g_trunc
    assign emit_low = emit_cnt[OUT_COUNT_W-1:0];
  end else begin : g_ext
    assign emit_low = {{(OUT_COUNT_W - COUNT_WIDTH){1'b0}}, emit_cnt};
  end

  // Job flags, cleared by a finish.
  always_comb begin
    sat_nxt = sat_r;
    ovf_nxt = ovf_r;
    if (is_finish) begin
      sat_nxt = 1'b0;
      ovf_nxt = 1'b0;
    end else begin
      if (is_source && (|sat_vec)) begin
        sat_nxt = 1'b1;
      end
      if (is_append && act_vec[MAX_PATTERN-1]) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (is_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, captured on a finish transfer.
  always_ff @(posedge clk) begin
    if (is_finish) begin
      out_count_r <= emit_low;
      out_sat_r   <= sat_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_count            = out_count_r;
  assign out_count_saturated  = out_sat_r;
  assign out_pattern_overflow = out_ovf_r;

  // Occupied cells always form an unbroken run from cell 0.
  a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_vec + MAX_PATTERN'(1)) & act_vec) == '0)
    else $error("cell occupancy is not contiguous");

  // A finish empties the whole row.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    is_finish |=> (act_vec == '0))
    else $error("row not cleared after finish");

  // A finish always leaves a result waiting.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_finish |=> out_valid_r)
    else $error("finish produced no result");

  // The overflow flag only rises when every cell was occupied.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(act_vec[MAX_PATTERN-1]))
    else $error("overflow flagged with free cells");

endmodule

/* hdl/dsc_cell.sv */
// ----------------------------------------------------------------------------
// Distinct subsequence counter cell
// Holds one pattern byte and the count for the prefix ending at it.
// ----------------------------------------------------------------------------
module dsc_cell #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsc_pkg::dsc_ctl_t      ctl,
  input  logic                   prev_active,
  input  logic [COUNT_WIDTH-1:0] prev_cnt,
  output logic                   active,
  output logic [COUNT_WIDTH-1:0] cnt,
  output logic                   sat_evt
);
  import dsc_pkg::*;

  logic                   active_r;
  logic                   active_nxt;
  logic [SYM_W-1:0]       sym_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH:0]   sum;
  logic                   take;
  logic                   hit;

  // This cell takes an appended byte when it is the first free one.
  assign take = ctl.load & ~active_r & prev_active;

  // A matching source byte adds the neighbour's old count.
  assign hit = ctl.step & active_r & (sym_r == ctl.symbol);
  assign sum = {1'b0, cnt_r} + {1'b0, prev_cnt};

  assign sat_evt = hit & sum[COUNT_WIDTH];
  assign active  = active_r;
  assign cnt     = cnt_r;

  // Occupancy of the cell.
  always_comb begin
    active_nxt = active_r;
    if (ctl.clear) begin
      active_nxt = 1'b0;
    end else if (take) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Pattern byte and saturating prefix count.
  always_ff @(posedge clk) begin
    if (take) begin
      sym_r <= ctl.symbol;
      cnt_r <= '0;
    end else if (hit) begin
      cnt_r <= sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct subsequence counter testbench
// Streams pattern, source and finish transfers into the counter under random
// idling on both channels. A behavioural copy of the prefix count row predicts
// every finish result, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dsc_pkg::*;

  localparam int PATTERN_DEPTH   = 64;
  localparam int ITEMS_PER_PHASE = 385;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
  } job_item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic                   saturated;
    logic                   overflow;
  } tally_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_action = 2'd0;
  logic [SYM_W-1:0] in_symbol = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [31:0]      out_count;
  logic             out_count_saturated;
  logic             out_pattern_overflow;

  // Transfers waiting to be driven, and finish results still to arrive.
  job_item_t job_items[$];
  tally_t    due_tallies[$];

  int   issued = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_taken = 1'b0;

  // Behavioural state of the counting row.
  logic [SYM_W-1:0]       pat_bytes [PATTERN_DEPTH];
  logic [OUT_COUNT_W-1:0] prefix_tally [PATTERN_DEPTH];
  int                     pat_len = 0;
  logic                   sat_seen = 1'b0;
  logic                   ovf_seen = 1'b0;

  distinct_subsequence_counter_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_symbol            (in_symbol),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_count            (out_count),
    .out_count_saturated  (out_count_saturated),
    .out_pattern_overflow (out_pattern_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted transfer to the prefix counts and queue any result.
  function automatic void step_prefix_counts(job_item_t item);
    logic [OUT_COUNT_W:0]   sum;
    logic [OUT_COUNT_W-1:0] below;
    tally_t                 res;
    case (item.action)
      ACT_APPEND: begin
        if (pat_len < PATTERN_DEPTH) begin
          pat_bytes[pat_len] = item.symbol;
          prefix_tally[pat_len] = '0;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      ACT_SOURCE: begin
        // Walking downwards means every position reads the counts from before this byte.
        for (int k = pat_len - 1; k >= 0; k--) begin
          if (pat_bytes[k] == item.symbol) begin
            below = (k == 0) ? OUT_COUNT_W'(1) : prefix_tally[k - 1];
            sum = {1'b0, prefix_tally[k]} + {1'b0, below};
            if (sum[OUT_COUNT_W]) begin
              prefix_tally[k] = '1;
              sat_seen = 1'b1;
            end else begin
              prefix_tally[k] = sum[OUT_COUNT_W-1:0];
            end
          end
        end
      end
      ACT_FINISH: begin
        res.count = (pat_len == 0) ? OUT_COUNT_W'(1) : prefix_tally[pat_len - 1];
        res.saturated = sat_seen;
        res.overflow = ovf_seen;
        due_tallies.push_back(res);
        pat_len = 0;
        sat_seen = 1'b0;
        ovf_seen = 1'b0;
      end
      default: begin
        // The unused code leaves everything as it was.
      end
    endcase
  endfunction

  function automatic void push_item(logic [1:0] action, logic [SYM_W-1:0] symbol);
    job_item_t item;
    item.action = action;
    item.symbol = symbol;
    job_items.push_back(item);
    if (action != ACT_UNUSED) begin
      issued++;
    end
  endfunction

  // One job: a pattern, a source stream mostly over a narrow alphabet, then a finish; or random noise items.
  task automatic add_job();
    int         kind;
    int         plen;
    int         slen;
    int         span;
    int         pick;
    logic [7:0] base;
    kind = $urandom_range(99);
    base = 8'($urandom_range(255));
    if (kind < 5) begin
      // Fill past capacity so that trailing appends are dropped.
      plen = PATTERN_DEPTH + $urandom_range(1, 6);
      span = $urandom_range(1, 3);
      slen = $urandom_range(0, 40);
    end else if (kind < 12) begin
      // A run of one byte against a long matching source drives counts to the maximum.
      plen = $urandom_range(10, 20);
      span = 1;
      slen = $urandom_range(60, 90);
    end else if (kind < 20) begin
      // Noise: any action, any byte, finishes included.
      repeat ($urandom_range(1, 12)) begin
        push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      return;
    end else if (kind < 25) begin
      // Source bytes with no pattern loaded.
      plen = 0;
      span = $urandom_range(1, 256);
      slen = $urandom_range(0, 6);
    end else begin
      plen = ($urandom_range(9) == 0) ? $urandom_range(9, PATTERN_DEPTH) : $urandom_range(1, 8);
      span = $urandom_range(1, 4);
      slen = $urandom_range(0, 40);
    end
    for (int i = 0; i < plen; i++) begin
      push_item(ACT_APPEND, 8'(base + $urandom_range(span - 1)));
    end
    for (int i = 0; i < slen; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_item(ACT_UNUSED, 8'($urandom_range(255)));
      end
      if (pick < 8) begin
        push_item(ACT_SOURCE, 8'($urandom_range(255)));
      end else begin
        push_item(ACT_SOURCE, 8'(base + $urandom_range(span - 1)));
      end
    end
    push_item(ACT_FINISH, 8'($urandom_range(255)));
  endtask

  // Driver: present the next transfer once the previous one has gone.
  always @(negedge clk) begin : driver
    job_item_t item;
    if (rst_n && (!in_valid || in_taken)) begin
      if (job_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item = job_items.pop_front();
        in_valid  <= 1'b1;
        in_action <= item.action;
        in_symbol <= item.symbol;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check result transfers, then feed accepted inputs to the model.
  always @(posedge clk) begin : monitor
    job_item_t taken;
    tally_t    seen;
    tally_t    want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.count = out_count;
        seen.saturated = out_count_saturated;
        seen.overflow = out_pattern_overflow;
        if (due_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result: count=%0d saturated=%0b overflow=%0b",
                     seen.count, seen.saturated, seen.overflow);
          end
        end else begin
          want = due_tallies.pop_front();
          if (want !== seen) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display({"result mismatch: expected count=%0d saturated=%0b overflow=%0b,",
                        " got count=%0d saturated=%0b overflow=%0b"},
                       want.count, want.saturated, want.overflow,
                       seen.count, seen.saturated, seen.overflow);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        taken.action = in_action;
        taken.symbol = in_symbol;
        step_prefix_counts(taken);
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** distinct_subsequence_counter_top: FAILED **");
      $finish;
    end
  end

  initial begin : control
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    #1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      issued = 0;
      if (phase == 0) begin
        // Empty pattern, a source byte with no pattern, and the unused code.
        push_item(ACT_FINISH, 8'hFF);
        push_item(ACT_SOURCE, 8'h00);
        push_item(ACT_UNUSED, 8'hFF);
        push_item(ACT_FINISH, 8'h00);
        // Extreme byte values in both the pattern and the source.
        push_item(ACT_APPEND, 8'h00);
        push_item(ACT_APPEND, 8'hFF);
        push_item(ACT_SOURCE, 8'hFF);
        push_item(ACT_SOURCE, 8'h00);
        push_item(ACT_UNUSED, 8'hAA);
        push_item(ACT_SOURCE, 8'hFF);
        push_item(ACT_SOURCE, 8'h00);
        push_item(ACT_SOURCE, 8'hFF);
        push_item(ACT_FINISH, 8'h55);
        // A repeated pattern byte, where the old counts matter.
        push_item(ACT_APPEND, 8'h61);
        push_item(ACT_APPEND, 8'h61);
        push_item(ACT_SOURCE, 8'h61);
        push_item(ACT_SOURCE, 8'h61);
        push_item(ACT_SOURCE, 8'h61);
        push_item(ACT_FINISH, 8'h00);
      end
      while (issued < ITEMS_PER_PHASE) begin
        add_job();
      end
      // Wait until every queued transfer has been sent and every expected result has arrived.
      while (job_items.size() != 0 || in_valid || due_tallies.size() != 0) begin
        @(negedge clk);
        #1;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** distinct_subsequence_counter_top: PASSED **");
    end else begin
      $display("** distinct_subsequence_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dsc_pkg.sv
hdl/dsc_cell.sv
hdl/distinct_subsequence_counter_top.sv
tb/sv/testbench.sv
